[hdl/upd_pkg.sv]
// upd_pkg: shared types, constants and helpers for the URL percent decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package upd_pkg;

   localparam logic [7:0] PCT_CHAR    = 8'h25;
   localparam int         MAX_RESULTS = 3;
   localparam int         CNT_W       = $clog2(MAX_RESULTS + 1);

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_word_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_word_type;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_PCT   = 2'd1,
      PH_DIGIT = 2'd2
   } phase_type;

   // bit 4 set: not a hex digit; bits 3:0: digit value
   function automatic logic [4:0] hex_value(input logic [7:0] ch);
      logic [4:0] res;
      res = 5'h10;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         res = {1'b0, ch[3:0]};
      end else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66)) begin
         res = {1'b0, ch[3:0] + 4'd9};
      end
      return res;
   endfunction

endpackage

`default_nettype wire

[hdl/url_percent_decoder.sv]
// url_percent_decoder: byte-serial percent-escape decoder, top level.
// Depends on upd_pkg.
// The first result word is valid in the cycle after the input word is accepted.
// Throughput: one input word per cycle while rsp_ready is high and each word yields
// at most one result; a failed escape or a flushed '%' yields two or three words,
// drained one per cycle from the three-entry result buffer, which sets the input stall.
// Reset (synchronous): phase returns to idle and the result buffer empties.
`timescale 1ns / 1ps
`default_nettype none

module url_percent_decoder
   import upd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_word_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_word_type      rsp_data
);

   phase_type    phase_ff, phase_in;
   logic [7:0]   held_ff, held_in;
   rsp_word_type buf_ff [MAX_RESULTS];
   rsp_word_type buf_in [MAX_RESULTS];
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   rsp_word_type     res [MAX_RESULTS];
   logic [CNT_W-1:0] res_cnt;
   logic [4:0]       hi_hex, lo_hex;
   logic             req_fire, rsp_fire;

   assign rsp_valid = (cnt_ff != '0);
   assign rsp_data  = buf_ff[0];
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign req_ready = (cnt_ff == '0) || (cnt_ff == CNT_W'(1) && rsp_ready);
   assign req_fire  = req_valid && req_ready;

   assign hi_hex = hex_value(held_ff);
   assign lo_hex = hex_value(req_data.in_byte);

   // next state
   always_comb begin
      phase_in = phase_ff;
      held_in  = held_ff;
      if (req_fire) begin
         unique case (phase_ff)
            PH_PCT: begin
               if (req_data.in_last) begin
                  phase_in = PH_IDLE;
               end else begin
                  phase_in = PH_DIGIT;
                  held_in  = req_data.in_byte;
               end
            end
            PH_DIGIT: begin
               phase_in = PH_IDLE;
            end
            default: begin
               if (req_data.in_byte == PCT_CHAR && !req_data.in_last) begin
                  phase_in = PH_PCT;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
         endcase
      end
   end

   // result words for the word at the input
   always_comb begin
      for (int k = 0; k < MAX_RESULTS; k++) begin
         res[k] = '0;
      end
      res_cnt = '0;
      unique case (phase_ff)
         PH_PCT: begin
            if (req_data.in_last) begin
               res[0]  = '{out_byte: PCT_CHAR, out_last: 1'b0};
               res[1]  = '{out_byte: req_data.in_byte, out_last: 1'b1};
               res_cnt = CNT_W'(2);
            end
         end
         PH_DIGIT: begin
            if (!hi_hex[4] && !lo_hex[4]) begin
               res[0]  = '{out_byte: {hi_hex[3:0], lo_hex[3:0]},
                           out_last: req_data.in_last};
               res_cnt = CNT_W'(1);
            end else begin
               res[0]  = '{out_byte: PCT_CHAR, out_last: 1'b0};
               res[1]  = '{out_byte: held_ff, out_last: 1'b0};
               res[2]  = '{out_byte: req_data.in_byte, out_last: req_data.in_last};
               res_cnt = CNT_W'(3);
            end
         end
         default: begin
            if (!(req_data.in_byte == PCT_CHAR && !req_data.in_last)) begin
               res[0]  = '{out_byte: req_data.in_byte, out_last: req_data.in_last};
               res_cnt = CNT_W'(1);
            end
         end
      endcase
   end

   // result buffer: load on accept, shift toward entry 0 on drain
   always_comb begin
      for (int k = 0; k < MAX_RESULTS; k++) begin
         buf_in[k] = buf_ff[k];
      end
      cnt_in = cnt_ff;
      if (req_fire) begin
         for (int k = 0; k < MAX_RESULTS; k++) begin
            buf_in[k] = res[k];
         end
         cnt_in = res_cnt;
      end else if (rsp_fire) begin
         for (int k = 0; k < MAX_RESULTS - 1; k++) begin
            buf_in[k] = buf_ff[k+1];
         end
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
      for (int k = 0; k < MAX_RESULTS; k++) begin
         buf_ff[k] <= buf_in[k];
      end
   end

endmodule

`default_nettype wire

[dv/url_percent_decoder_tb.sv]
// url_percent_decoder_tb: self-checking bench for the percent-escape decoder.
// Queue-fed driver and checking monitor with random idling. Needs upd_pkg and
// url_percent_decoder.
`timescale 1ns / 1ps

module url_percent_decoder_tb
   import upd_pkg::*;
();

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_WORDS = 250;
   localparam int HOLD_AFTER   = 60;
   localparam int HOLD_CYCLES  = 100;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_data;

   req_word_type pending_words[$];
   rsp_word_type expected_chars[$];

   // decoder state as predicted
   phase_type    esc_phase = PH_IDLE;
   logic [7:0]   held_digit;

   int errors, words_in, words_out, decoded_count, passthru_count, cycle_count;
   int send_gap, send_steady, recv_idle, recv_steady, hold_left;
   bit hold_done;

   url_percent_decoder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // -1 when not a hex digit
   function automatic int nibble_of(input logic [7:0] ch);
      if (ch >= 8'h30 && ch <= 8'h39) return int'(ch) - 'h30;
      if (ch >= 8'h41 && ch <= 8'h46) return int'(ch) - 'h41 + 10;
      if (ch >= 8'h61 && ch <= 8'h66) return int'(ch) - 'h61 + 10;
      return -1;
   endfunction

   function automatic void expect_char(input logic [7:0] b, input logic l);
      rsp_word_type w;
      w.out_byte = b;
      w.out_last = l;
      expected_chars.push_back(w);
   endfunction

   function automatic void decode_word(input req_word_type w);
      int hi, lo;
      case (esc_phase)
         PH_PCT: begin
            if (w.in_last) begin
               expect_char(PCT_CHAR, 1'b0);
               expect_char(w.in_byte, 1'b1);
               passthru_count++;
               esc_phase = PH_IDLE;
            end else begin
               held_digit = w.in_byte;
               esc_phase  = PH_DIGIT;
            end
         end
         PH_DIGIT: begin
            hi = nibble_of(held_digit);
            lo = nibble_of(w.in_byte);
            if (hi >= 0 && lo >= 0) begin
               expect_char(8'(hi * 16 + lo), w.in_last);
               decoded_count++;
            end else begin
               expect_char(PCT_CHAR, 1'b0);
               expect_char(held_digit, 1'b0);
               expect_char(w.in_byte, w.in_last);
               passthru_count++;
            end
            esc_phase = PH_IDLE;
         end
         default: begin
            esc_phase = PH_IDLE;
            if (w.in_byte == PCT_CHAR && !w.in_last) begin
               esc_phase = PH_PCT;
            end else begin
               expect_char(w.in_byte, w.in_last);
            end
         end
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   function automatic logic [7:0] pick_hex();
      int k;
      k = $urandom_range(0, 21);
      if (k < 10) return 8'(8'h30 + k);
      if (k < 16) return 8'(8'h41 + k - 10);
      return 8'(8'h61 + k - 16);
   endfunction

   function automatic logic [7:0] pick_edge_char();
      case ($urandom_range(0, 5))
         0: return 8'h2F;
         1: return 8'h3A;
         2: return 8'h40;
         3: return 8'h47;
         4: return 8'h60;
         default: return 8'h67;
      endcase
   endfunction

   function automatic void add_word(input logic [7:0] b, input logic l);
      req_word_type w;
      w.in_byte = b;
      w.in_last = l;
      pending_words.push_back(w);
   endfunction

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         add_word(s[i], i == s.len() - 1);
      end
   endfunction

   // mostly well-formed escapes, with broken ones, odd chars and cut-off tails
   function automatic void add_random_text();
      logic [7:0] text[$];
      int r;
      repeat ($urandom_range(1, 6)) begin
         r = $urandom_range(0, 99);
         if (r < 45) begin
            text.push_back(PCT_CHAR);
            text.push_back(pick_hex());
            text.push_back(pick_hex());
         end else if (r < 60) begin
            text.push_back(PCT_CHAR);
            text.push_back($urandom_range(0, 1) ? pick_hex() : 8'($urandom_range(0, 255)));
            text.push_back($urandom_range(0, 1) ? pick_edge_char() : 8'($urandom_range(0, 255)));
         end else if (r < 70) begin
            text.push_back(pick_edge_char());
         end else begin
            text.push_back(8'($urandom_range(0, 255)));
         end
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
         text.push_back(PCT_CHAR);
      end else if (r < 16) begin
         text.push_back(PCT_CHAR);
         text.push_back(pick_hex());
      end
      foreach (text[i]) begin
         add_word(text[i], i == text.size() - 1);
      end
   endfunction

   function automatic int next_send_gap();
      if (send_steady > 0) begin
         send_steady--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         send_steady = $urandom_range(15, 40);
      end
      return pick_gap();
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         esc_phase = PH_IDLE;
         send_gap  = 0;
      end else begin
         if (req_valid && req_ready) begin
            decode_word(req_data);
            words_in++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               req_data  <= pending_words.pop_front();
               req_valid <= 1'b1;
               send_gap = next_send_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            words_out++;
            if (expected_chars.size() == 0) begin
               $error("unexpected word: out_byte %h out_last %b",
                      rsp_data.out_byte, rsp_data.out_last);
               errors++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_data.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %h, got %h", want.out_byte, rsp_data.out_byte);
                  errors++;
               end
               if (rsp_data.out_last !== want.out_last) begin
                  $error("out_last: expected %b, got %b", want.out_last, rsp_data.out_last);
                  errors++;
               end
            end
         end
         // one long back-pressure stretch so the result buffer holds and the input stalls
         if (!hold_done && words_out >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (recv_idle > 0) begin
            recv_idle--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (recv_steady > 0) begin
               recv_steady--;
            end else if ($urandom_range(0, 29) == 0) begin
               recv_steady = $urandom_range(20, 60);
            end else if ($urandom_range(0, 4) == 0) begin
               recv_idle = pick_gap();
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      int directed;
      add_word(8'h00, 1'b0);
      add_word(8'hFF, 1'b1);
      add_text("%7e%Ff%00");
      add_text("%G1%a/");
      add_text("%%41x");
      add_text("%");
      add_text("%4");
      directed = pending_words.size();
      while (pending_words.size() - directed < RANDOM_WORDS) begin
         add_random_text();
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_valid) @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d words in, %0d words out, %0d errors",
               words_in, words_out, errors);
      $display("summary: %0d escapes decoded, %0d escapes or flushes passed through",
               decoded_count, passthru_count);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
